@@ src/line_follow_pd_junction_assert.svh @@
// assertion macros for the line follower block
// included by the top level; no other dependencies
`ifndef LINE_FOLLOW_PD_JUNCTION_ASSERT_SVH
`define LINE_FOLLOW_PD_JUNCTION_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while in reset
`define LFPDJ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lfpdj same-cycle check failed");
// next-cycle implication, disabled while in reset
`define LFPDJ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lfpdj next-cycle check failed");
`else
`define LFPDJ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LFPDJ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ src/lfpdj_pkg.sv @@
// shared types and constants of the pd line follower
// no dependencies
package lfpdj_pkg;

  localparam int unsigned SPEED_MAX = 250;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_DERIV_GAIN      = 3'd1,
    CFG_BASE_SPEED      = 3'd2,
    CFG_CENTER_POSITION = 3'd3,
    CFG_JUNCTION_KIND   = 3'd4,
    CFG_THRESHOLD_LEFT  = 3'd5,
    CFG_THRESHOLD_MID   = 3'd6,
    CFG_THRESHOLD_RIGHT = 3'd7
  } cfg_idx_t;

  // junction patterns; codes above the last one never match
  typedef enum logic [3:0] {
    JK_BLACK_T         = 4'd0,
    JK_BLACK_RIGHT     = 4'd1,
    JK_BLACK_LEFT      = 4'd2,
    JK_WHITE_T         = 4'd3,
    JK_WHITE_RIGHT     = 4'd4,
    JK_WHITE_LEFT      = 4'd5,
    JK_BLACK_LEFT_ONLY = 4'd6,
    JK_BLACK_RIGHT_ONLY= 4'd7,
    JK_BLACK_T_WHITE_C = 4'd8,
    JK_WHITE_T_BLACK_C = 4'd9
  } junction_kind_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [7:0]  base_speed;
    logic [11:0] center_position;
    logic [3:0]  junction_kind;
    logic [9:0]  threshold_left;
    logic [9:0]  threshold_mid;
    logic [9:0]  threshold_right;
  } cfg_t;

endpackage

@@ src/lfpdj_correction.sv @@
// pd correction: two gain products, truncating divide by 256, speed clamp
// depends on lfpdj_pkg
module lfpdj_correction (
  input  lfpdj_pkg::cfg_t     cfg,
  input  logic signed [12:0]  err,
  input  logic signed [13:0]  diff,
  output logic [7:0]          left_speed,
  output logic [7:0]          right_speed
);
  import lfpdj_pkg::*;

  logic signed [29:0] prod_p;
  logic signed [30:0] prod_d;
  logic signed [31:0] acc;
  logic signed [31:0] acc_b;
  logic signed [23:0] corr;
  logic signed [25:0] sum_l;
  logic signed [25:0] sum_r;
  logic signed [25:0] base_s;

  assign prod_p = 30'($signed({1'b0, cfg.prop_gain})) * 30'(err);
  assign prod_d = 31'($signed({1'b0, cfg.deriv_gain})) * 31'(diff);
  assign acc    = 32'(prod_p) + 32'(prod_d);
  // bias negatives so the arithmetic shift truncates toward zero
  assign acc_b  = acc + (acc[31] ? 32'sd255 : 32'sd0);
  assign corr   = acc_b[31:8];

  assign base_s = 26'($signed({1'b0, cfg.base_speed}));
  assign sum_l  = base_s + 26'(corr);
  assign sum_r  = base_s - 26'(corr);

  function automatic logic [7:0] clamp_speed(input logic signed [25:0] v);
    logic [7:0] res;
    if (v < 26'sd0) begin
      res = 8'd0;
    end else if (v > 26'(SPEED_MAX)) begin
      res = 8'(SPEED_MAX);
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  assign left_speed  = clamp_speed(sum_l);
  assign right_speed = clamp_speed(sum_r);

endmodule

@@ src/lfpdj_junction.sv @@
// junction pattern match with strict per-sensor threshold compares
// depends on lfpdj_pkg
module lfpdj_junction (
  input  lfpdj_pkg::cfg_t cfg,
  input  logic [9:0]      sample_left,
  input  logic [9:0]      sample_mid,
  input  logic [9:0]      sample_right,
  output logic            found
);
  import lfpdj_pkg::*;

  logic lh, ll, mh, ml, rh, rl;

  assign lh = sample_left  > cfg.threshold_left;
  assign ll = sample_left  < cfg.threshold_left;
  assign mh = sample_mid   > cfg.threshold_mid;
  assign ml = sample_mid   < cfg.threshold_mid;
  assign rh = sample_right > cfg.threshold_right;
  assign rl = sample_right < cfg.threshold_right;

  always_comb begin
    case (junction_kind_t'(cfg.junction_kind))
      JK_BLACK_T:          found = lh && mh && rh;
      JK_BLACK_RIGHT:      found = ll && mh && rh;
      JK_BLACK_LEFT:       found = lh && mh && rl;
      JK_WHITE_T:          found = ll && ml && rl;
      JK_WHITE_RIGHT:      found = lh && ml && rl;
      JK_WHITE_LEFT:       found = ll && ml && rh;
      JK_BLACK_LEFT_ONLY:  found = lh;
      JK_BLACK_RIGHT_ONLY: found = rh;
      JK_BLACK_T_WHITE_C:  found = lh && ml && rh;
      JK_WHITE_T_BLACK_C:  found = ll && mh && rl;
      default:             found = 1'b0;
    endcase
  end

endmodule

@@ src/line_follow_pd_junction.sv @@
// top level of the pd line follower with junction detector
// depends on lfpdj_pkg, lfpdj_correction, lfpdj_junction and the assert header
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | line_position, sample_left/mid/right
//   out_    | output    | out_valid/stall  | left_speed, right_speed, junction_found
//   cfg_    | input     | cfg_we           | cfg_index, cfg_wdata
//
// one request per cycle sustained unless out_stall holds the result register; each
// request fills the input register; gain products and clamp feed the result register
// the error and its difference to the previous error are formed at accept time,
// so the derivative state updates in the same cycle a request is taken
// rst_n is synchronous; it clears both valid stages, the previous error and
// loads the register defaults
// out_stall holds the result register; in_stall rises only when both stages are full
`include "line_follow_pd_junction_assert.svh"

module line_follow_pd_junction (
  input  logic        clk,
  input  logic        rst_n,
  // input request
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_line_position,
  input  logic [9:0]  in_sample_left,
  input  logic [9:0]  in_sample_mid,
  input  logic [9:0]  in_sample_right,
  // result request
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_left_speed,
  output logic [7:0]  out_right_speed,
  output logic        out_junction_found,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import lfpdj_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // derivative state
  logic signed [12:0] prev_err_r;

  // input stage
  logic               s1_vld_r;
  logic signed [12:0] s1_err_r;
  logic signed [13:0] s1_diff_r;
  logic [9:0]         s1_sl_r;
  logic [9:0]         s1_sm_r;
  logic [9:0]         s1_sr_r;

  // result stage
  logic               out_vld_r;
  logic [7:0]         out_left_r;
  logic [7:0]         out_right_r;
  logic               out_jf_r;

  logic               in_acc;
  logic               out_free;
  logic               s1_adv;
  logic signed [12:0] err;
  logic signed [13:0] diff;
  logic [7:0]         left_speed;
  logic [7:0]         right_speed;
  logic               junction_found;

  // result register frees when empty or being taken
  assign out_free = !out_vld_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_free;
  // input side only waits when the input stage cannot move on
  assign in_stall = s1_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // error is at most 4095 in magnitude, so 13 bits signed hold it
  assign err  = 13'($signed({1'b0, in_line_position}))
              - 13'($signed({1'b0, cfg_r.center_position}));
  assign diff = 14'(err) - 14'(prev_err_r);

  // configuration, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain       <= 16'd256;
      cfg_r.deriv_gain      <= 16'd0;
      cfg_r.base_speed      <= 8'd100;
      cfg_r.center_position <= 12'd2000;
      cfg_r.junction_kind   <= 4'd0;
      cfg_r.threshold_left  <= 10'd500;
      cfg_r.threshold_mid   <= 10'd500;
      cfg_r.threshold_right <= 10'd500;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:       cfg_r.prop_gain       <= cfg_wdata;
        CFG_DERIV_GAIN:      cfg_r.deriv_gain      <= cfg_wdata;
        CFG_BASE_SPEED:      cfg_r.base_speed      <= cfg_wdata[7:0];
        CFG_CENTER_POSITION: cfg_r.center_position <= cfg_wdata[11:0];
        CFG_JUNCTION_KIND:   cfg_r.junction_kind   <= cfg_wdata[3:0];
        CFG_THRESHOLD_LEFT:  cfg_r.threshold_left  <= cfg_wdata[9:0];
        CFG_THRESHOLD_MID:   cfg_r.threshold_mid   <= cfg_wdata[9:0];
        CFG_THRESHOLD_RIGHT: cfg_r.threshold_right <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= 13'sd0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_err_r <= err;
      end
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_err_r  <= err;
      s1_diff_r <= diff;
      s1_sl_r   <= in_sample_left;
      s1_sm_r   <= in_sample_mid;
      s1_sr_r   <= in_sample_right;
    end
    if (s1_adv) begin
      out_left_r  <= left_speed;
      out_right_r <= right_speed;
      out_jf_r    <= junction_found;
    end
  end

  lfpdj_correction u_corr (
    .cfg         (cfg_r),
    .err         (s1_err_r),
    .diff        (s1_diff_r),
    .left_speed  (left_speed),
    .right_speed (right_speed)
  );

  lfpdj_junction u_junc (
    .cfg          (cfg_r),
    .sample_left  (s1_sl_r),
    .sample_mid   (s1_sm_r),
    .sample_right (s1_sr_r),
    .found        (junction_found)
  );

  assign out_valid          = out_vld_r;
  assign out_left_speed     = out_left_r;
  assign out_right_speed    = out_right_r;
  assign out_junction_found = out_jf_r;

  // speeds never leave the clamp range
  `LFPDJ_ASSERT_IMP(a_speed_range, clk, rst_n, out_vld_r, (out_left_r <= 8'd250) && (out_right_r <= 8'd250))
  // input only held back when both stages are full and the result is held
  `LFPDJ_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, s1_vld_r && out_vld_r && out_stall)
  // every accepted request leaves its error as the derivative state
  `LFPDJ_ASSERT_NXT(a_prev_err, clk, rst_n, in_acc, (prev_err_r == $past(err)) && s1_vld_r)

endmodule

@@ verif/line_follow_pd_junction_tb.sv @@
// self-checking testbench for the pd line follower with junction detector
// holds its own predictor of the speeds and the junction flag
// depends on lfpdj_pkg and the line_follow_pd_junction rtl
module line_follow_pd_junction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpdj_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 600;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 150;
  localparam int PRINT_CAP   = 50;

  // one sensor request: line position plus the three reflectance samples
  typedef struct packed {
    logic [11:0] position;
    logic [9:0]  left;
    logic [9:0]  mid;
    logic [9:0]  right;
  } reading_t;

  // one predicted motor command
  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic       junction_found;
  } motor_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_line_position = '0;
  logic [9:0]  in_sample_left = '0;
  logic [9:0]  in_sample_mid = '0;
  logic [9:0]  in_sample_right = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_left_speed;
  logic [7:0]  out_right_speed;
  logic        out_junction_found;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // predictor state: register copy and the error kept from the last request
  cfg_t              pd_cfg;
  logic signed [12:0] last_error;

  reading_t   reading_q[$];     // requests waiting to be offered
  motor_cmd_t motor_cmd_q[$];   // predicted commands waiting for their result

  int idle_pct = 26;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  line_follow_pd_junction u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_line_position   (in_line_position),
    .in_sample_left     (in_sample_left),
    .in_sample_mid      (in_sample_mid),
    .in_sample_right    (in_sample_right),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_speed     (out_left_speed),
    .out_right_speed    (out_right_speed),
    .out_junction_found (out_junction_found),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // saturate a signed speed into 0..SPEED_MAX
  function automatic logic [7:0] clamp_speed(longint v);
    if (v < 0) return 8'd0;
    if (v > longint'(SPEED_MAX)) return 8'(SPEED_MAX);
    return v[7:0];
  endfunction

  // pd correction, differential speeds and the junction pattern for one request
  function automatic motor_cmd_t follow_line(reading_t rd);
    longint     err;
    longint     acc;
    longint     corr;
    logic       lh, ll, mh, ml, rh, rl;
    motor_cmd_t cmd;
    err  = longint'(rd.position) - longint'(pd_cfg.center_position);
    acc  = longint'(pd_cfg.prop_gain) * err
         + longint'(pd_cfg.deriv_gain) * (err - longint'(last_error));
    corr = acc / 256;   // signed divide truncates toward zero
    last_error = err[12:0];
    cmd.left_speed  = clamp_speed(longint'(pd_cfg.base_speed) + corr);
    cmd.right_speed = clamp_speed(longint'(pd_cfg.base_speed) - corr);
    // strict tests: a sample equal to its threshold is neither high nor low
    lh = rd.left > pd_cfg.threshold_left;
    ll = rd.left < pd_cfg.threshold_left;
    mh = rd.mid > pd_cfg.threshold_mid;
    ml = rd.mid < pd_cfg.threshold_mid;
    rh = rd.right > pd_cfg.threshold_right;
    rl = rd.right < pd_cfg.threshold_right;
    case (junction_kind_t'(pd_cfg.junction_kind))
      JK_BLACK_T:          cmd.junction_found = lh && mh && rh;
      JK_BLACK_RIGHT:      cmd.junction_found = ll && mh && rh;
      JK_BLACK_LEFT:       cmd.junction_found = lh && mh && rl;
      JK_WHITE_T:          cmd.junction_found = ll && ml && rl;
      JK_WHITE_RIGHT:      cmd.junction_found = lh && ml && rl;
      JK_WHITE_LEFT:       cmd.junction_found = ll && ml && rh;
      JK_BLACK_LEFT_ONLY:  cmd.junction_found = lh;
      JK_BLACK_RIGHT_ONLY: cmd.junction_found = rh;
      JK_BLACK_T_WHITE_C:  cmd.junction_found = lh && ml && rh;
      JK_WHITE_T_BLACK_C:  cmd.junction_found = ll && mh && rl;
      default:             cmd.junction_found = 1'b0;   // unused codes never match
    endcase
    return cmd;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t mismatch on %s at result %0d: got %0d want %0d",
               $realtime, what, results_seen, got, want);
  endtask

  // sender: offers queued requests, predicts each one as it is taken
  always @(posedge clk) begin : sender
    reading_t cur;
    reading_t nxt;
    bit       taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        cur = {in_line_position, in_sample_left, in_sample_mid, in_sample_right};
        motor_cmd_q.push_back(follow_line(cur));
      end
      // a stalled request keeps its payload; a new one is loaded only after a take
      if (!in_valid || taken) begin
        if (reading_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = reading_q.pop_front();
          in_line_position <= nxt.position;
          in_sample_left   <= nxt.left;
          in_sample_mid    <= nxt.mid;
          in_sample_right  <= nxt.right;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs up the pipe
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct);
      if (hold_left != 0) hold_left--;
    end
  end

  // result checker: every taken result against the oldest prediction
  always @(posedge clk) begin : result_check
    motor_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (motor_cmd_q.size() == 0) begin
        report_mismatch("result with no request pending", 0, 0);
      end else begin
        want = motor_cmd_q.pop_front();
        if (out_left_speed !== want.left_speed)
          report_mismatch("left_speed", out_left_speed, want.left_speed);
        if (out_right_speed !== want.right_speed)
          report_mismatch("right_speed", out_right_speed, want.right_speed);
        if (out_junction_found !== want.junction_found)
          report_mismatch("junction_found", out_junction_found, want.junction_found);
      end
      results_seen <= results_seen + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // writes every register; only called while nothing is in flight
  task automatic program_regs(cfg_t c);
    write_reg(CFG_PROP_GAIN, c.prop_gain);
    write_reg(CFG_DERIV_GAIN, c.deriv_gain);
    write_reg(CFG_BASE_SPEED, c.base_speed);
    write_reg(CFG_CENTER_POSITION, c.center_position);
    write_reg(CFG_JUNCTION_KIND, c.junction_kind);
    write_reg(CFG_THRESHOLD_LEFT, c.threshold_left);
    write_reg(CFG_THRESHOLD_MID, c.threshold_mid);
    write_reg(CFG_THRESHOLD_RIGHT, c.threshold_right);
    @(posedge clk);
    cfg_we <= 1'b0;
    pd_cfg = c;
    @(negedge clk);
  endtask

  // wait until every request is out and answered, then let both stages drain
  task automatic wait_quiet();
    do @(negedge clk);
    while (reading_q.size() != 0 || in_valid || motor_cmd_q.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_reading(int pos, int l, int m, int r);
    reading_t rd;
    rd.position = pos[11:0];
    rd.left     = l[9:0];
    rd.mid      = m[9:0];
    rd.right    = r[9:0];
    reading_q.push_back(rd);
  endfunction

  // mostly near the threshold so junction patterns actually match
  function automatic int pick_sample(int thr);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return thr;
    if (pick <= 4 && thr < 1023) return thr + $urandom_range(1, (1023 - thr < 200) ? 1023 - thr : 200);
    if (pick <= 8 && thr > 0) return thr - $urandom_range(1, (thr < 200) ? thr : 200);
    return $urandom_range(0, 1023);
  endfunction

  function automatic logic [15:0] rand_gain();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [9:0] rand_threshold();
    return ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 1000));
  endfunction

  initial begin : stimulus
    cfg_t c;
    int   walk;
    int   k;
    int   n;
    // register defaults after reset
    pd_cfg = '{prop_gain: 16'd256, deriv_gain: 16'd0, base_speed: 8'd100,
               center_position: 12'd2000, junction_kind: JK_BLACK_T,
               threshold_left: 10'd500, threshold_mid: 10'd500, threshold_right: 10'd500};
    last_error = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: unit gain, black t, thresholds at 500
    add_reading(2000, 501, 501, 501);
    add_reading(2000, 500, 501, 501);    // left equals threshold
    add_reading(0, 1023, 1023, 1023);
    add_reading(4000, 0, 0, 0);
    add_reading(4095, 1023, 0, 1023);
    add_reading(2100, 499, 501, 501);
    add_reading(1900, 501, 500, 501);    // middle equals threshold
    add_reading(2000, 501, 501, 500);    // right equals threshold
    wait_quiet();

    // top of every register's range, unused junction code
    c = '{prop_gain: 16'hFFFF, deriv_gain: 16'hFFFF, base_speed: 8'hFF,
          center_position: 12'hFFF, junction_kind: 4'hF,
          threshold_left: 10'h3FF, threshold_mid: 10'h3FF, threshold_right: 10'h3FF};
    program_regs(c);
    add_reading(0, 1023, 1023, 1023);
    add_reading(4095, 0, 0, 0);
    add_reading(0, 1022, 1022, 1022);
    add_reading(4095, 1023, 0, 1023);
    add_reading(2048, 511, 511, 511);
    wait_quiet();

    // everything at zero: speeds pinned at zero, thresholds at zero
    c = '{prop_gain: 16'd0, deriv_gain: 16'd0, base_speed: 8'd0,
          center_position: 12'd0, junction_kind: JK_WHITE_T_BLACK_C,
          threshold_left: 10'd0, threshold_mid: 10'd0, threshold_right: 10'd0};
    program_regs(c);
    add_reading(4095, 0, 1, 0);
    add_reading(0, 0, 1023, 0);
    add_reading(4095, 1, 1, 1);
    add_reading(0, 1023, 1023, 1023);
    wait_quiet();

    // base at the clamp ceiling, single sensor pattern at the threshold top
    c = '{prop_gain: 16'd256, deriv_gain: 16'd256, base_speed: 8'd250,
          center_position: 12'd2000, junction_kind: JK_BLACK_LEFT_ONLY,
          threshold_left: 10'd1000, threshold_mid: 10'd1000, threshold_right: 10'd1000};
    program_regs(c);
    add_reading(2001, 1001, 0, 0);
    add_reading(1999, 1000, 0, 0);
    add_reading(4000, 1023, 1023, 1023);
    wait_quiet();

    // random phases: one per junction code, line position follows a random walk
    walk = 2000;
    for (k = 0; k < 16; k++) begin
      c.prop_gain       = rand_gain();
      c.deriv_gain      = rand_gain();
      c.base_speed      = 8'($urandom_range(0, 255));
      c.center_position = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                                      : 12'($urandom_range(0, 4000));
      c.junction_kind   = k[3:0];
      c.threshold_left  = rand_threshold();
      c.threshold_mid   = rand_threshold();
      c.threshold_right = rand_threshold();
      program_regs(c);
      // two phases run with no idling on either side
      idle_pct = (k == 3 || k == 4) ? 0 : 26;
      for (n = 0; n < 63; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          walk = $urandom_range(0, 4095);
        end else begin
          walk = walk + int'($urandom_range(0, 400)) - 200;
          if (walk < 0) walk = 0;
          if (walk > 4000) walk = 4000;
        end
        add_reading(walk, pick_sample(c.threshold_left), pick_sample(c.threshold_mid),
                    pick_sample(c.threshold_right));
      end
      wait_quiet();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/lfpdj_pkg.sv
src/lfpdj_correction.sv
src/lfpdj_junction.sv
src/line_follow_pd_junction.sv
verif/line_follow_pd_junction_tb.sv
